// ===== hdl/keypad_pin_lock_unit_assert.svh =====
// assertion macros for the keypad lock block
`ifndef KEYPAD_PIN_LOCK_UNIT_ASSERT_SVH
`define KEYPAD_PIN_LOCK_UNIT_ASSERT_SVH

// checked on every clock edge while out of reset
`define KPL_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked on every clock edge, reset included
`define KPL_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/kpl_pkg.sv =====
package kpl_pkg;

	typedef logic [1:0] digit_t;

	typedef enum logic [1:0] {
		VERDICT_NONE  = 2'd0,
		VERDICT_WRONG = 2'd1,
		VERDICT_RIGHT = 2'd2
	} verdict_t;

	typedef enum logic {
		REQ_SAMPLE = 1'b0,
		REQ_START  = 1'b1
	} req_t;

	// configuration register indexes
	localparam logic [1:0] REG_LEVEL1  = 2'd0;
	localparam logic [1:0] REG_LEVEL2  = 2'd1;
	localparam logic [1:0] REG_LEVEL3  = 2'd2;
	localparam logic [1:0] REG_RELEASE = 2'd3;

	localparam logic [7:0] LEVEL1_RESET  = 8'h3F;
	localparam logic [7:0] LEVEL2_RESET  = 8'h94;
	localparam logic [7:0] LEVEL3_RESET  = 8'hB3;
	localparam logic [7:0] RELEASE_RESET = 8'hE4;

	localparam logic [7:0] LFSR_TAPS  = 8'hB8;
	localparam logic [2:0] NUM_DIGITS = 3'd4;
	localparam logic [2:0] LAST_STAGE = 3'd4;

	function automatic logic [7:0] lfsr_next(input logic [7:0] cur);
		logic [7:0] shifted;
		shifted = {1'b0, cur[7:1]};
		return cur[0] ? (shifted ^ LFSR_TAPS) : shifted;
	endfunction

	// digit 0 is the most significant pair
	function automatic digit_t expected_digit(input logic [7:0] code, input logic [1:0] pos);
		logic [1:0] sel;
		sel = 2'd3 - pos;
		return code[{sel, 1'b0} +: 2];
	endfunction

endpackage

// ===== hdl/keypad_pin_lock_unit.sv =====
// channel | valid    | stall     | payload
// in      | in_valid | in_stall  | req_type, sample, start_seed
// out     | out_valid| out_stall | digit_accepted, verdict, stage_now, digits_entered
// cfg     | cfg_wr_en| -         | cfg_index, cfg_wdata
//
// one word per cycle sustained while out_stall is low; a taken word moves from the input
// register to the output register, the lock update running between the two registers.
// all lock state is updated in the cycle the word leaves the input register.
// reset restores the thresholds and clears the game; there is no clearing pass.
// a stalled output holds its word while the input register still takes one more word.
module keypad_pin_lock_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_wdata,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       req_type,
	input  logic [7:0] sample,
	input  logic [7:0] start_seed,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       digit_accepted,
	output logic [1:0] verdict,
	output logic [2:0] stage_now,
	output logic [2:0] digits_entered
);

	logic [7:0] level1_q, level2_q, level3_q, release_q;

	// input register
	logic       valid_s1;
	logic       req_s1;
	logic [7:0] sample_s1;
	logic [7:0] seed_s1;

	// lock state
	kpl_pkg::digit_t entered_q [4];
	logic [2:0]      count_q;
	logic [7:0]      lfsr_q;
	logic [2:0]      stage_q;
	logic            seen_q;
	logic            held_q;
	logic            started_q;

	// output register
	logic              out_valid_q;
	logic              accepted_q;
	kpl_pkg::verdict_t verdict_q;
	logic [2:0]        stage_out_q;
	logic [2:0]        count_out_q;

	logic advance, fire, take;

	// next state
	kpl_pkg::digit_t   entered_n [4];
	logic [2:0]        count_n;
	logic [7:0]        lfsr_n;
	logic [2:0]        stage_n;
	logic              seen_n, held_n, started_n;
	logic              accepted_n;
	kpl_pkg::verdict_t verdict_n;

	assign advance  = !out_valid_q || !out_stall;
	assign fire     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;
	assign take     = in_valid && !in_stall;

	always_comb begin
		kpl_pkg::digit_t key;
		logic            released;
		logic [1:0]      idx;
		logic            hit;
		logic            ok;
		logic [7:0]      seed;

		entered_n  = entered_q;
		count_n    = count_q;
		lfsr_n     = lfsr_q;
		stage_n    = stage_q;
		seen_n     = seen_q;
		held_n     = held_q;
		started_n  = started_q;
		accepted_n = 1'b0;
		verdict_n  = kpl_pkg::VERDICT_NONE;

		key = 2'd0;
		if (sample_s1 > level1_q) key = 2'd1;
		if (sample_s1 > level2_q) key = 2'd2;
		if (sample_s1 > level3_q) key = 2'd3;
		released = sample_s1 > release_q;
		idx      = count_q[1:0];
		hit      = seen_q && !released && (entered_q[idx] == key);
		ok       = 1'b1;
		seed     = (seed_s1 == 8'd0) ? 8'd1 : seed_s1;

		if (req_s1 == kpl_pkg::REQ_START) begin
			lfsr_n    = kpl_pkg::lfsr_next(seed);
			stage_n   = 3'd0;
			for (int i = 0; i < 4; i++) entered_n[i] = 2'd0;
			count_n   = 3'd0;
			seen_n    = 1'b0;
			held_n    = 1'b0;
			started_n = 1'b1;
		end else if (started_q) begin
			// debounce: second matching sample arms the press, release completes it
			if (hit) begin
				seen_n = 1'b0;
				held_n = 1'b1;
			end
			if (!held_n && !released) begin
				entered_n[idx] = key;
				seen_n         = 1'b1;
			end
			if (held_n && released) begin
				held_n     = 1'b0;
				accepted_n = 1'b1;
			end

			if (accepted_n) begin
				if (count_q < kpl_pkg::NUM_DIGITS) count_n = count_q + 3'd1;
				// first stage checks each digit as it comes in
				if (stage_q == 3'd0 && count_n < kpl_pkg::NUM_DIGITS &&
				    entered_n[idx] != kpl_pkg::expected_digit(lfsr_q, idx)) begin
					verdict_n = kpl_pkg::VERDICT_WRONG;
					count_n   = 3'd0;
				end
			end

			if (count_n == kpl_pkg::NUM_DIGITS) begin
				if (stage_q == 3'd0) begin
					ok = entered_n[3] == kpl_pkg::expected_digit(lfsr_q, 2'd3);
				end else if (stage_q < kpl_pkg::LAST_STAGE) begin
					for (int i = 0; i < 4; i++)
						if (entered_n[i] != kpl_pkg::expected_digit(lfsr_q, 2'(i)))
							ok = 1'b0;
				end
				if (ok) begin
					if (stage_q < kpl_pkg::LAST_STAGE) stage_n = stage_q + 3'd1;
					lfsr_n    = kpl_pkg::lfsr_next(lfsr_q);
					verdict_n = kpl_pkg::VERDICT_RIGHT;
				end else begin
					verdict_n = kpl_pkg::VERDICT_WRONG;
				end
				for (int i = 0; i < 4; i++) entered_n[i] = 2'd0;
				count_n = 3'd0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level1_q  <= kpl_pkg::LEVEL1_RESET;
			level2_q  <= kpl_pkg::LEVEL2_RESET;
			level3_q  <= kpl_pkg::LEVEL3_RESET;
			release_q <= kpl_pkg::RELEASE_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				kpl_pkg::REG_LEVEL1:  level1_q  <= cfg_wdata;
				kpl_pkg::REG_LEVEL2:  level2_q  <= cfg_wdata;
				kpl_pkg::REG_LEVEL3:  level3_q  <= cfg_wdata;
				kpl_pkg::REG_RELEASE: release_q <= cfg_wdata;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 4; i++) entered_q[i] <= 2'd0;
			count_q     <= 3'd0;
			lfsr_q      <= 8'd1;
			stage_q     <= 3'd0;
			seen_q      <= 1'b0;
			held_q      <= 1'b0;
			started_q   <= 1'b0;
		end else begin
			if (take) valid_s1 <= 1'b1;
			else if (fire) valid_s1 <= 1'b0;
			if (advance) out_valid_q <= valid_s1;
			if (fire) begin
				entered_q <= entered_n;
				count_q   <= count_n;
				lfsr_q    <= lfsr_n;
				stage_q   <= stage_n;
				seen_q    <= seen_n;
				held_q    <= held_n;
				started_q <= started_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			req_s1    <= req_type;
			sample_s1 <= sample;
			seed_s1   <= start_seed;
		end
		if (fire) begin
			accepted_q  <= accepted_n;
			verdict_q   <= verdict_n;
			stage_out_q <= stage_n;
			count_out_q <= count_n;
		end
	end

	assign out_valid      = out_valid_q;
	assign digit_accepted = accepted_q;
	assign verdict        = verdict_q;
	assign stage_now      = stage_out_q;
	assign digits_entered = count_out_q;

endmodule

// ===== hdl/kpl_checker.sv =====
`include "keypad_pin_lock_unit_assert.svh"

module kpl_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic       digit_accepted,
	input logic [1:0] verdict,
	input logic [2:0] stage_now,
	input logic [2:0] digits_entered
);

	// a verdict only comes with a completed key press
	`KPL_ASSERT(a_verdict_needs_press, out_valid && verdict != kpl_pkg::VERDICT_NONE |-> digit_accepted, "verdict without accepted digit")

	// any verdict ends the attempt
	`KPL_ASSERT(a_verdict_clears_count, out_valid && verdict != kpl_pkg::VERDICT_NONE |-> digits_entered == 3'd0, "digits left after verdict")

	// the count never rests at four, the stage saturates
	`KPL_ASSERT(a_ranges, out_valid |-> digits_entered < 3'd4 && stage_now <= kpl_pkg::LAST_STAGE, "stage or digit count out of range")

	`KPL_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(verdict) && $stable(stage_now) && $stable(digits_entered), "stalled word changed")

	// an edge seen in reset leaves the output empty
	`KPL_ASSERT_ALWAYS(a_reset_idle, !arst_n |=> !out_valid, "output valid during reset")

endmodule

bind keypad_pin_lock_unit kpl_checker u_kpl_checker (.*);

// ===== bench/keypad_pin_lock_unit_tb.sv =====
module keypad_pin_lock_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic              accepted;
		kpl_pkg::verdict_t verdict;
		logic [2:0]        stage;
		logic [2:0]        digits;
	} lock_result_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_wr_en = 1'b0;
	logic [1:0] cfg_index = kpl_pkg::REG_LEVEL1;
	logic [7:0] cfg_wdata = 8'h00;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic       req_type = kpl_pkg::REQ_SAMPLE;
	logic [7:0] sample = 8'h00;
	logic [7:0] start_seed = 8'h00;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic       digit_accepted;
	logic [1:0] verdict;
	logic [2:0] stage_now;
	logic [2:0] digits_entered;

	// predicted lock state
	logic [7:0]      th [4];
	kpl_pkg::digit_t pin_digits [4];
	logic [2:0]      count_held;
	logic [7:0]      code_reg;
	logic [2:0]      stage_reg;
	logic            first_seen;
	logic            held;
	logic            game_on;

	lock_result_t pending_lock_results [$];
	int fail_count = 0;
	int words_sent = 0;
	bit quiet = 1'b0;
	int hold_asked = 0;
	int hold_done = 0;
	int hold_left = 0;

	keypad_pin_lock_unit i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.req_type       (req_type),
		.sample         (sample),
		.start_seed     (start_seed),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.digit_accepted (digit_accepted),
		.verdict        (verdict),
		.stage_now      (stage_now),
		.digits_entered (digits_entered)
	);

	always #4 clk = ~clk;

	function automatic logic [7:0] code_step(input logic [7:0] c);
		return (c >> 1) ^ (c[0] ? kpl_pkg::LFSR_TAPS : 8'h00);
	endfunction

	function automatic kpl_pkg::digit_t pin_digit_at(input logic [7:0] c,
			input logic [1:0] pos);
		int sh;
		sh = 6 - 2 * int'(pos);
		return kpl_pkg::digit_t'((c >> sh) & 8'h03);
	endfunction

	// later thresholds override earlier ones
	function automatic void quantize(input logic [7:0] s, output kpl_pkg::digit_t key,
			output logic rel);
		key = 2'd0;
		rel = 1'b0;
		if (s > th[kpl_pkg::REG_LEVEL1]) key = 2'd1;
		if (s > th[kpl_pkg::REG_LEVEL2]) key = 2'd2;
		if (s > th[kpl_pkg::REG_LEVEL3]) key = 2'd3;
		if (s > th[kpl_pkg::REG_RELEASE]) rel = 1'b1;
	endfunction

	// scan from a random start for a reading that gives the wanted key or a release
	function automatic logic [7:0] pick_sample(input logic want_rel, input kpl_pkg::digit_t k);
		logic [7:0] s;
		logic [7:0] off;
		kpl_pkg::digit_t kk;
		logic rr;
		off = 8'($urandom_range(255));
		for (int i = 0; i < 256; i++) begin
			s = off + 8'(i);
			quantize(s, kk, rr);
			if (want_rel ? rr : (!rr && kk == k))
				return s;
		end
		return off;
	endfunction

	function automatic void clear_attempt();
		foreach (pin_digits[i])
			pin_digits[i] = 2'd0;
		count_held = 3'd0;
	endfunction

	function automatic void step_lock(input kpl_pkg::req_t rt, input logic [7:0] s,
			input logic [7:0] seed);
		lock_result_t r;
		kpl_pkg::digit_t key;
		logic rel;
		logic [1:0] idx;
		logic [1:0] p;
		logic ok;
		r.accepted = 1'b0;
		r.verdict = kpl_pkg::VERDICT_NONE;
		if (rt == kpl_pkg::REQ_START) begin
			code_reg = code_step((seed == 8'h00) ? 8'h01 : seed);
			stage_reg = 3'd0;
			clear_attempt();
			first_seen = 1'b0;
			held = 1'b0;
			game_on = 1'b1;
		end else if (game_on) begin
			idx = count_held[1:0];
			quantize(s, key, rel);
			if (first_seen && !rel && pin_digits[idx] == key) begin
				first_seen = 1'b0;
				held = 1'b1;
			end
			if (!held && !rel) begin
				pin_digits[idx] = key;
				first_seen = 1'b1;
			end
			if (held && rel) begin
				held = 1'b0;
				r.accepted = 1'b1;
			end
			if (r.accepted) begin
				if (count_held < kpl_pkg::NUM_DIGITS)
					count_held = count_held + 3'd1;
				// stage zero checks each digit as it comes
				if (stage_reg == 3'd0 && count_held < kpl_pkg::NUM_DIGITS) begin
					p = count_held[1:0] - 2'd1;
					if (pin_digits[p] != pin_digit_at(code_reg, p)) begin
						r.verdict = kpl_pkg::VERDICT_WRONG;
						count_held = 3'd0;
					end
				end
			end
			if (count_held == kpl_pkg::NUM_DIGITS) begin
				ok = 1'b1;
				if (stage_reg == 3'd0) begin
					ok = (pin_digits[3] == pin_digit_at(code_reg, 2'd3));
				end else if (stage_reg < kpl_pkg::LAST_STAGE) begin
					for (int i = 0; i < 4; i++)
						if (pin_digits[i] != pin_digit_at(code_reg, 2'(i)))
							ok = 1'b0;
				end
				if (ok) begin
					if (stage_reg < kpl_pkg::LAST_STAGE)
						stage_reg = stage_reg + 3'd1;
					code_reg = code_step(code_reg);
					r.verdict = kpl_pkg::VERDICT_RIGHT;
				end else begin
					r.verdict = kpl_pkg::VERDICT_WRONG;
				end
				clear_attempt();
			end
		end
		r.stage = stage_reg;
		r.digits = count_held;
		pending_lock_results.push_back(r);
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
		fail_count++;
	endtask

	// receiver: random stall, or a long counted hold-off when asked
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_asked != hold_done) begin
			hold_done <= hold_asked;
			hold_left <= 300;
			out_stall <= 1'b1;
		end else begin
			out_stall <= !quiet && ($urandom_range(99) < 36);
		end
	end

	always @(posedge clk) begin : check_results
		lock_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_lock_results.size() == 0) begin
				report_mismatch("word with nothing pending", 1, 0);
			end else begin
				want = pending_lock_results.pop_front();
				if (digit_accepted !== want.accepted)
					report_mismatch("digit_accepted", digit_accepted, want.accepted);
				if (verdict !== want.verdict)
					report_mismatch("verdict", verdict, want.verdict);
				if (stage_now !== want.stage)
					report_mismatch("stage_now", stage_now, want.stage);
				if (digits_entered !== want.digits)
					report_mismatch("digits_entered", digits_entered, want.digits);
			end
		end
	end

	task automatic send_word(input kpl_pkg::req_t rt, input logic [7:0] s,
			input logic [7:0] seed);
		if (!quiet) begin
			while ($urandom_range(99) < 36) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		req_type <= rt;
		sample <= s;
		start_seed <= seed;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		step_lock(rt, s, seed);
		words_sent++;
	endtask

	task automatic send_sample(input logic [7:0] s);
		send_word(kpl_pkg::REQ_SAMPLE, s, 8'($urandom_range(255)));
	endtask

	task automatic start_game(input logic [7:0] seed);
		send_word(kpl_pkg::REQ_START, 8'($urandom_range(255)), seed);
	endtask

	task automatic press_key(input kpl_pkg::digit_t k);
		int n_hold;
		int n_rel;
		n_hold = $urandom_range(3, 2);
		n_rel = $urandom_range(2, 1);
		repeat (n_hold)
			send_sample(pick_sample(1'b0, k));
		repeat (n_rel)
			send_sample(pick_sample(1'b1, 2'd0));
	endtask

	// digit index follows the attempt in progress so a correct entry lines up
	task automatic enter_pin(input bit correct);
		int wrong_pos;
		kpl_pkg::digit_t k;
		wrong_pos = correct ? 4 : $urandom_range(3);
		for (int n = 0; n < 4; n++) begin
			k = pin_digit_at(code_reg, count_held[1:0]);
			if (n == wrong_pos)
				k = k ^ kpl_pkg::digit_t'($urandom_range(3, 1));
			press_key(k);
		end
	endtask

	task automatic drain_block();
		in_valid <= 1'b0;
		while (pending_lock_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		th[idx] = val;
		@(posedge clk);
	endtask

	task automatic write_thresholds(input logic [7:0] l1, input logic [7:0] l2,
			input logic [7:0] l3, input logic [7:0] rel);
		drain_block();
		write_reg(kpl_pkg::REG_LEVEL1, l1);
		write_reg(kpl_pkg::REG_LEVEL2, l2);
		write_reg(kpl_pkg::REG_LEVEL3, l3);
		write_reg(kpl_pkg::REG_RELEASE, rel);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic play_mix(input int target);
		int pick;
		while (words_sent < target) begin
			pick = $urandom_range(99);
			if (pick < 8) begin
				start_game(($urandom_range(9) == 0) ? 8'h00 : 8'($urandom_range(255)));
			end else if (pick < 72) begin
				enter_pin($urandom_range(99) < 80);
			end else if (pick < 86) begin
				repeat ($urandom_range(4, 1))
					send_sample(8'($urandom_range(255)));
			end else begin
				// press that may break: the second sample is a random key, or there is none
				send_sample(pick_sample(1'b0, kpl_pkg::digit_t'($urandom_range(3))));
				if ($urandom_range(1))
					send_sample(pick_sample(1'b0, kpl_pkg::digit_t'($urandom_range(3))));
				send_sample(pick_sample(1'b1, 2'd0));
			end
		end
	endtask

	task automatic test_directed();
		// ignored before the first start
		send_sample(8'h00);
		send_sample(8'hFF);
		send_sample(8'h80);
		// zero seed is replaced by one
		start_game(8'h00);
		start_game(8'hFF);
		// wrong first digit in stage zero
		send_sample(8'h00);
		send_sample(8'h00);
		send_sample(8'hFF);
		enter_pin(1'b1);
	endtask

	task automatic test_thresholds();
		write_thresholds(8'h00, 8'h00, 8'h00, 8'h00);
		play_mix(words_sent + 100);
		write_thresholds(8'hFF, 8'hFF, 8'hFF, 8'hFF);
		play_mix(words_sent + 60);
		write_thresholds(8'hC8, 8'h64, 8'h32, 8'hFA);
		play_mix(words_sent + 120);
		write_thresholds(8'h10, 8'h50, 8'hA0, 8'hFE);
		play_mix(words_sent + 150);
		write_thresholds(8'($urandom_range(80)), 8'($urandom_range(150, 81)),
			8'($urandom_range(200, 151)), 8'($urandom_range(254, 201)));
		play_mix(words_sent + 150);
		write_thresholds(kpl_pkg::LEVEL1_RESET, kpl_pkg::LEVEL2_RESET,
			kpl_pkg::LEVEL3_RESET, kpl_pkg::RELEASE_RESET);
	endtask

	task automatic test_pressure();
		quiet = 1'b1;
		hold_asked <= hold_asked + 1;
		play_mix(words_sent + 40);
		quiet = 1'b0;
	endtask

	task automatic test_random();
		play_mix(words_sent + 300);
		quiet = 1'b1;
		play_mix(words_sent + 200);
		quiet = 1'b0;
		play_mix(1650);
	endtask

	initial begin
		th[kpl_pkg::REG_LEVEL1] = kpl_pkg::LEVEL1_RESET;
		th[kpl_pkg::REG_LEVEL2] = kpl_pkg::LEVEL2_RESET;
		th[kpl_pkg::REG_LEVEL3] = kpl_pkg::LEVEL3_RESET;
		th[kpl_pkg::REG_RELEASE] = kpl_pkg::RELEASE_RESET;
		clear_attempt();
		code_reg = 8'h01;
		stage_reg = 3'd0;
		first_seen = 1'b0;
		held = 1'b0;
		game_on = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_pressure();
		test_thresholds();
		test_random();
		drain_block();
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/kpl_pkg.sv
hdl/keypad_pin_lock_unit.sv
hdl/kpl_checker.sv
bench/keypad_pin_lock_unit_tb.sv
